// ----- sv/hrbt_pkg.sv -----
// hrbt_pkg: shared types, character codes and phase/tag encodings for the
// request byte tagger. No dependencies; imported by every module of the block.
`default_nettype none

package hrbt_pkg;

    localparam int LENGTH_BITS_DEF = 24;
    localparam int BODY_LEN_W      = 24;
    localparam int CLASS_W         = 4;
    localparam int STATUS_W        = 3;
    localparam int KPOS_W          = 4;

    typedef logic [7:0] t_byte;
    typedef logic [KPOS_W-1:0] t_kpos;

    localparam t_byte CH_CR    = 8'h0D;
    localparam t_byte CH_LF    = 8'h0A;
    localparam t_byte CH_SP    = 8'h20;
    localparam t_byte CH_TAB   = 8'h09;
    localparam t_byte CH_SLASH = 8'h2F;
    localparam t_byte CH_QUEST = 8'h3F;
    localparam t_byte CH_AMP   = 8'h26;
    localparam t_byte CH_EQ    = 8'h3D;
    localparam t_byte CH_COLON = 8'h3A;
    localparam t_byte CH_DOT   = 8'h2E;

    localparam t_kpos KPOS_FULL = 4'd14;
    localparam t_kpos KPOS_MISS = 4'd15;

    typedef enum logic [3:0] {
        PH_START,
        PH_METHOD,
        PH_URL,
        PH_QUERY,
        PH_PROTO,
        PH_REQ_END,
        PH_HEADER,
        PH_HDR_END,
        PH_BODY,
        PH_DONE,
        PH_BAD_METH,
        PH_BAD_URI,
        PH_BAD_VER,
        PH_BAD_LINE
    } t_phase;

    typedef enum logic [CLASS_W-1:0] {
        CL_DELIM,
        CL_METHOD,
        CL_PATH,
        CL_QKEY,
        CL_QVAL,
        CL_PROTO,
        CL_VERSION,
        CL_HKEY,
        CL_HVAL,
        CL_BODY
    } t_class;

    typedef enum logic [STATUS_W-1:0] {
        ST_BUSY,
        ST_DONE,
        ST_BAD_METHOD,
        ST_BAD_URI,
        ST_BAD_VERSION,
        ST_BAD_LINE
    } t_status;

    typedef struct packed {
        logic colon;
        logic hkdone;
        logic hval;
        logic hkey;
        logic ver;
        logic pslash;
        logic proto;
        logic qeq;
        logic qval;
        logic qkey;
        logic path;
    } t_flags;

    typedef struct packed {
        t_phase     phase;
        t_flags     flags;
        t_kpos      kpos;
        logic [1:0] blank;
    } t_ctl;

    typedef struct packed {
        t_class  cls;
        logic    first;
        logic    closed;
        t_status status;
    } t_tag;

    localparam t_ctl CTL_RESET = '{phase: PH_START, flags: '0, kpos: '0, blank: 2'd0};

    // characters of the Content-Length header name
    function automatic t_byte cl_char(input t_kpos pos);
        t_byte ch;
        case (pos)
            4'd0:    ch = 8'h43;
            4'd1:    ch = 8'h6F;
            4'd2:    ch = 8'h6E;
            4'd3:    ch = 8'h74;
            4'd4:    ch = 8'h65;
            4'd5:    ch = 8'h6E;
            4'd6:    ch = 8'h74;
            4'd7:    ch = 8'h2D;
            4'd8:    ch = 8'h4C;
            4'd9:    ch = 8'h65;
            4'd10:   ch = 8'h6E;
            4'd11:   ch = 8'h67;
            4'd12:   ch = 8'h74;
            4'd13:   ch = 8'h68;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

`default_nettype wire

// ----- sv/hrbt_step.sv -----
// hrbt_step: per-byte parser step, from the current parser state and one byte
// to the next state and the byte's tags. Depends on hrbt_pkg.
`default_nettype none

module hrbt_step
    import hrbt_pkg::*;
#(
    parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
    input  t_byte                  i_byte,
    input  logic                   i_new,
    input  t_ctl                   i_ctl,
    input  logic [LENGTH_BITS-1:0] i_len,
    input  logic [LENGTH_BITS-1:0] i_left,
    output t_ctl                   o_ctl,
    output logic [LENGTH_BITS-1:0] o_len,
    output logic [LENGTH_BITS-1:0] o_left,
    output t_tag                   o_tag
);

    t_ctl                   cur;
    logic [LENGTH_BITS-1:0] cur_len;
    logic [LENGTH_BITS-1:0] cur_left;
    logic [LENGTH_BITS+3:0] len_x10;
    logic [LENGTH_BITS-1:0] len_sat;
    logic                   c_blank;
    logic                   c_skip;
    logic                   c_upper;
    logic                   c_digit;
    t_phase                 ph;
    t_flags                 f;
    t_kpos                  kp;
    logic [1:0]             bl;
    logic [LENGTH_BITS-1:0] ln;
    logic [LENGTH_BITS-1:0] lf;
    t_class                 cls;
    logic                   first;
    logic                   closed;

    assign cur      = i_new ? CTL_RESET : i_ctl;
    assign cur_len  = i_new ? '0 : i_len;
    assign cur_left = i_new ? '0 : i_left;

    assign c_blank = (i_byte == CH_SP) || (i_byte == CH_TAB);
    assign c_skip  = (i_byte == CH_CR) || (i_byte == CH_LF) || (i_byte == CH_SP);
    assign c_upper = (i_byte >= 8'h41) && (i_byte <= 8'h5A);
    assign c_digit = (i_byte >= 8'h30) && (i_byte <= 8'h39);

    // len * 10 + digit, saturating
    assign len_x10 = ({4'd0, cur_len} << 3) + ({4'd0, cur_len} << 1)
                   + {{LENGTH_BITS{1'b0}}, i_byte[3:0]};
    assign len_sat = (len_x10[LENGTH_BITS+3:LENGTH_BITS] != 4'd0) ? '1
                   : len_x10[LENGTH_BITS-1:0];

    always_comb begin
        ph     = cur.phase;
        f      = cur.flags;
        kp     = cur.kpos;
        bl     = cur.blank;
        ln     = cur_len;
        lf     = cur_left;
        cls    = CL_DELIM;
        first  = 1'b0;
        closed = 1'b0;
        unique case (cur.phase) inside
            PH_START: begin
                if (c_skip) begin
                end else if (c_upper) begin
                    ph    = PH_METHOD;
                    cls   = CL_METHOD;
                    first = 1'b1;
                end else begin
                    ph = PH_BAD_METH;
                end
            end
            PH_METHOD: begin
                if (c_blank) begin
                    closed = 1'b1;
                    ph     = PH_URL;
                end else begin
                    cls = CL_METHOD;
                end
            end
            PH_URL: begin
                if (i_byte == CH_SLASH) begin
                    cls = CL_PATH;
                    if (!f.path) begin
                        f.path = 1'b1;
                        first  = 1'b1;
                    end
                end else if (c_blank || i_byte == CH_QUEST) begin
                    if (f.path) begin
                        closed = 1'b1;
                        ph     = (i_byte == CH_QUEST) ? PH_QUERY : PH_PROTO;
                    end
                end else if (f.path) begin
                    cls = CL_PATH;
                end
            end
            PH_QUERY: begin
                if (c_skip && !(f.qkey || f.qval)) begin
                    ph = PH_BAD_URI;
                end else if (i_byte == CH_EQ) begin
                    if (f.qkey && !(f.qeq || f.qval)) closed = 1'b1;
                    f.qeq = 1'b1;
                end else if (c_blank || i_byte == CH_AMP) begin
                    if (f.qval || (f.qkey && !f.qeq)) closed = 1'b1;
                    f.qkey = 1'b0;
                    f.qval = 1'b0;
                    f.qeq  = 1'b0;
                    if (i_byte != CH_AMP) ph = PH_PROTO;
                end else begin
                    if (f.qeq && !f.qval) begin
                        f.qval = 1'b1;
                        f.qkey = 1'b1;
                        f.qeq  = 1'b0;
                        first  = 1'b1;
                    end else if (!f.qkey) begin
                        f.qkey = 1'b1;
                        first  = 1'b1;
                    end
                    cls = f.qval ? CL_QVAL : CL_QKEY;
                end
            end
            PH_PROTO: begin
                if (c_blank && !f.proto) begin
                end else if (i_byte == CH_SLASH) begin
                    if (f.proto && !f.pslash) closed = 1'b1;
                    f.pslash = 1'b1;
                end else if (f.pslash) begin
                    if (c_digit && !f.ver) begin
                        f.ver = 1'b1;
                        cls   = CL_VERSION;
                        first = 1'b1;
                    end else if (i_byte == CH_CR) begin
                        if (f.ver) closed = 1'b1;
                        ph = PH_REQ_END;
                    end else if (f.ver) begin
                        if (c_digit || i_byte == CH_DOT) cls = CL_VERSION;
                        else ph = PH_BAD_VER;
                    end
                end else begin
                    if (!f.proto) begin
                        f.proto = 1'b1;
                        first   = 1'b1;
                    end
                    cls = CL_PROTO;
                end
            end
            PH_REQ_END, PH_HDR_END: begin
                if (i_byte == CH_LF) begin
                    ph = PH_HEADER;
                    bl = 2'd1;
                end else begin
                    ph = PH_BAD_LINE;
                end
            end
            PH_HEADER: begin
                if (cur.blank == 2'd1 && i_byte == CH_CR) begin
                    bl = 2'd2;
                end else if (cur.blank == 2'd2 && i_byte == CH_LF) begin
                    bl = 2'd0;
                    if (cur_len != '0) begin
                        lf = cur_len;
                        ph = PH_BODY;
                    end else begin
                        ph = PH_DONE;
                    end
                end else begin
                    bl = 2'd0;
                    if (c_skip && !f.hkey) begin
                    end else if (i_byte == CH_COLON) begin
                        if (f.hkey && !f.colon) begin
                            f.hkdone = 1'b1;
                            f.colon  = 1'b1;
                            closed   = 1'b1;
                            if (kp == KPOS_FULL) ln = '0;
                            else kp = KPOS_MISS;
                        end else if (f.hval) begin
                            cls = CL_HVAL;
                            if (kp == KPOS_FULL) kp = KPOS_MISS;
                        end
                    end else if (i_byte == CH_CR) begin
                        if (f.hval || !f.colon) closed = 1'b1;
                        f.hkey   = 1'b0;
                        f.hval   = 1'b0;
                        f.hkdone = 1'b0;
                        f.colon  = 1'b0;
                        ph       = PH_HDR_END;
                    end else begin
                        if (!f.hkey) begin
                            f.hkey = 1'b1;
                            kp     = '0;
                            first  = 1'b1;
                        end
                        if (f.hkdone && !f.hval) begin
                            f.hval   = 1'b1;
                            f.hkdone = 1'b0;
                            first    = 1'b1;
                        end
                        if (f.hval) begin
                            cls = CL_HVAL;
                            if (kp == KPOS_FULL) begin
                                if (c_digit) ln = len_sat;
                                else if (i_byte != CH_SP) kp = KPOS_MISS;
                            end
                        end else begin
                            cls = CL_HKEY;
                            if (!f.colon && i_byte != CH_SP) begin
                                if (kp < KPOS_FULL && i_byte == cl_char(kp)) kp = kp + 4'd1;
                                else kp = KPOS_MISS;
                            end
                        end
                    end
                end
            end
            PH_BODY: begin
                cls = CL_BODY;
                if (cur_left == cur_len) first = 1'b1;
                if (cur_left != '0) lf = cur_left - 1'b1;
                if (lf == '0) ph = PH_DONE;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        o_ctl.phase  = ph;
        o_ctl.flags  = f;
        o_ctl.kpos   = kp;
        o_ctl.blank  = bl;
        o_len        = ln;
        o_left       = lf;
        o_tag.cls    = cls;
        o_tag.first  = first;
        o_tag.closed = closed;
        unique case (ph)
            PH_DONE:     o_tag.status = ST_DONE;
            PH_BAD_METH: o_tag.status = ST_BAD_METHOD;
            PH_BAD_URI:  o_tag.status = ST_BAD_URI;
            PH_BAD_VER:  o_tag.status = ST_BAD_VERSION;
            PH_BAD_LINE: o_tag.status = ST_BAD_LINE;
            default:     o_tag.status = ST_BUSY;
        endcase
    end

endmodule

`default_nettype wire

// ----- sv/http_request_byte_tagger.sv -----
// http_request_byte_tagger: top level with input register, parser state and
// result register around hrbt_step. Depends on hrbt_pkg and hrbt_step.
//
// Usage: one request byte enters on the input channel (i_valid, i_data_byte,
// i_new_request, o_stall) and one tag record leaves on the output channel
// (o_valid, o_byte_class, o_token_first, o_token_closed, o_status,
// o_body_length, i_stall). Each transfer takes place at a rising edge with
// valid high and stall low. i_new_request returns the parser to its start
// state just before its own byte is parsed.
// A byte accepted from the input channel is parsed out of the input register, and
// its result is written into the result register, with o_valid high, from which
// it can leave. Throughput is one byte per cycle while the receiver does not
// stall; the parser state loop runs from its own registers through hrbt_step alone.
// While the receiver stalls, the result register holds; one further byte may
// sit in the input register, and then o_stall rises until the result is taken.
// Reset (synchronous, active low) empties both registers and puts the parser
// in its start state with no length seen.
`default_nettype none

module http_request_byte_tagger
    import hrbt_pkg::*;
#(
    parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [7:0]            i_data_byte,
    input  logic                  i_new_request,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [CLASS_W-1:0]    o_byte_class,
    output logic                  o_token_first,
    output logic                  o_token_closed,
    output logic [STATUS_W-1:0]   o_status,
    output logic [BODY_LEN_W-1:0] o_body_length
);

    logic                   r_in_valid;
    t_byte                  r_byte;
    logic                   r_new;
    logic                   r_out_valid;
    t_tag                   r_tag;
    logic [BODY_LEN_W-1:0]  r_body_length;
    t_ctl                   r_ctl;
    logic [LENGTH_BITS-1:0] r_len;
    logic [LENGTH_BITS-1:0] r_left;
    t_ctl                   n_ctl;
    logic [LENGTH_BITS-1:0] n_len;
    logic [LENGTH_BITS-1:0] n_left;
    t_tag                   n_tag;
    logic                   out_ready;
    logic                   step_fire;

    assign out_ready = !r_out_valid || !i_stall;
    assign step_fire = r_in_valid && out_ready;
    assign o_stall   = r_in_valid && !out_ready;

    hrbt_step #(
        .LENGTH_BITS(LENGTH_BITS)
    ) u_step (
        .i_byte (r_byte),
        .i_new  (r_new),
        .i_ctl  (r_ctl),
        .i_len  (r_len),
        .i_left (r_left),
        .o_ctl  (n_ctl),
        .o_len  (n_len),
        .o_left (n_left),
        .o_tag  (n_tag)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_ctl       <= CTL_RESET;
            r_len       <= '0;
            r_left      <= '0;
        end else begin
            if (!o_stall) r_in_valid <= i_valid;
            if (out_ready) r_out_valid <= r_in_valid;
            if (step_fire) begin
                r_ctl  <= n_ctl;
                r_len  <= n_len;
                r_left <= n_left;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_byte <= i_data_byte;
            r_new  <= i_new_request;
        end
        if (step_fire) begin
            r_tag         <= n_tag;
            r_body_length <= BODY_LEN_W'(n_len);
        end
    end

    assign o_valid        = r_out_valid;
    assign o_byte_class   = r_tag.cls;
    assign o_token_first  = r_tag.first;
    assign o_token_closed = r_tag.closed;
    assign o_status       = r_tag.status;
    assign o_body_length  = r_body_length;

    a_body_left_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ctl.phase == PH_BODY |-> r_left != '0)
        else $error("body phase with nothing left to count");

    a_left_within_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_left <= r_len)
        else $error("body count exceeds content length");

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> r_in_valid && r_out_valid && i_stall)
        else $error("input stalled while a register is free");

    a_held_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> $stable(r_ctl) && $stable(r_len))
        else $error("parser state moved while result was held");

endmodule

`default_nettype wire

// ----- tb/hrbt_tag_checker.sv -----
// hrbt_tag_checker: watches both channels of the request byte tagger, predicts the
// tag of every accepted byte in order and compares each result field by field.
// Depends on hrbt_pkg for the phase, class and status encodings.
`default_nettype none

module hrbt_tag_checker
    import hrbt_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_req_valid,
    input  wire logic                  i_req_stall,
    input  wire logic [7:0]            i_req_byte,
    input  wire logic                  i_req_new,
    input  wire logic                  i_res_valid,
    input  wire logic                  i_res_stall,
    input  wire logic [CLASS_W-1:0]    i_res_class,
    input  wire logic                  i_res_first,
    input  wire logic                  i_res_closed,
    input  wire logic [STATUS_W-1:0]   i_res_status,
    input  wire logic [BODY_LEN_W-1:0] i_res_length,
    output int                         o_fail_count,
    output int                         o_pending
);

    localparam logic [0:13][7:0]        LEN_KEY   = "Content-Length";
    localparam logic [BODY_LEN_W-1:0]  LEN_LIMIT = '1;
    localparam t_byte CH_DIGIT_0 = 8'h30;
    localparam t_byte CH_DIGIT_9 = 8'h39;
    localparam t_byte CH_UPPER_A = 8'h41;
    localparam t_byte CH_UPPER_Z = 8'h5A;

    typedef struct packed {
        t_class                cls;
        logic                  first;
        logic                  closed;
        t_status               status;
        logic [BODY_LEN_W-1:0] len;
    } t_tag_rec;

    t_phase                phase;
    t_flags                flags;
    t_kpos                 kpos;
    logic [BODY_LEN_W-1:0] len_seen;
    logic [BODY_LEN_W-1:0] body_left;
    logic [1:0]            line_gap;

    t_tag_rec expected_tags[$];
    t_tag_rec head;
    t_tag_rec next_tag;
    int       mismatch_count = 0;

    assign o_fail_count = mismatch_count;

    task automatic parser_clear();
        phase     = PH_START;
        flags     = '0;
        kpos      = '0;
        len_seen  = '0;
        body_left = '0;
        line_gap  = 2'd0;
    endtask

    // digits of a matched length header, saturating
    task automatic take_value(input t_byte c);
        logic [35:0] acc;
        if (kpos == KPOS_FULL) begin
            if (c >= CH_DIGIT_0 && c <= CH_DIGIT_9) begin
                acc = 36'(len_seen) * 36'd10 + 36'(c - CH_DIGIT_0);
                len_seen = (acc > 36'(LEN_LIMIT)) ? LEN_LIMIT : acc[BODY_LEN_W-1:0];
            end else if (c != CH_SP) begin
                kpos = KPOS_MISS;
            end
        end
    endtask

    task automatic tag_byte(input t_byte c, input logic fresh, output t_tag_rec rec);
        t_flags  f;
        t_class  cls;
        logic    first;
        logic    closed;
        t_status st;
        logic    sp_tab;
        logic    skip;
        logic    digit;
        if (fresh) parser_clear();
        f      = flags;
        cls    = CL_DELIM;
        first  = 1'b0;
        closed = 1'b0;
        sp_tab = (c == CH_SP || c == CH_TAB);
        skip   = (c == CH_CR || c == CH_LF || c == CH_SP);
        digit  = (c >= CH_DIGIT_0 && c <= CH_DIGIT_9);
        case (phase)
            PH_START: begin
                if (skip) begin
                end else if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
                    phase = PH_METHOD;
                    cls   = CL_METHOD;
                    first = 1'b1;
                end else begin
                    phase = PH_BAD_METH;
                end
            end
            PH_METHOD: begin
                if (sp_tab) begin
                    closed = 1'b1;
                    phase  = PH_URL;
                end else begin
                    cls = CL_METHOD;
                end
            end
            PH_URL: begin
                if (c == CH_SLASH) begin
                    cls = CL_PATH;
                    if (!f.path) begin
                        f.path = 1'b1;
                        first  = 1'b1;
                    end
                end else if (sp_tab || c == CH_QUEST) begin
                    if (f.path) begin
                        closed = 1'b1;
                        phase  = (c == CH_QUEST) ? PH_QUERY : PH_PROTO;
                    end
                end else if (f.path) begin
                    cls = CL_PATH;
                end
            end
            PH_QUERY: begin
                if (skip && !(f.qkey || f.qval)) begin
                    phase = PH_BAD_URI;
                end else if (c == CH_EQ) begin
                    if (f.qkey && !(f.qeq || f.qval)) closed = 1'b1;
                    f.qeq = 1'b1;
                end else if (sp_tab || c == CH_AMP) begin
                    if (f.qval || (f.qkey && !f.qeq)) closed = 1'b1;
                    f.qkey = 1'b0;
                    f.qval = 1'b0;
                    f.qeq  = 1'b0;
                    if (c != CH_AMP) phase = PH_PROTO;
                end else begin
                    if (f.qeq && !f.qval) begin
                        f.qval = 1'b1;
                        f.qkey = 1'b1;
                        f.qeq  = 1'b0;
                        first  = 1'b1;
                    end else if (!f.qkey) begin
                        f.qkey = 1'b1;
                        first  = 1'b1;
                    end
                    cls = f.qval ? CL_QVAL : CL_QKEY;
                end
            end
            PH_PROTO: begin
                if (sp_tab && !f.proto) begin
                end else if (c == CH_SLASH) begin
                    if (f.proto && !f.pslash) closed = 1'b1;
                    f.pslash = 1'b1;
                end else if (f.pslash) begin
                    if (digit && !f.ver) begin
                        f.ver = 1'b1;
                        cls   = CL_VERSION;
                        first = 1'b1;
                    end else if (c == CH_CR) begin
                        if (f.ver) closed = 1'b1;
                        phase = PH_REQ_END;
                    end else if (f.ver) begin
                        if (digit || c == CH_DOT) cls = CL_VERSION;
                        else phase = PH_BAD_VER;
                    end
                end else begin
                    if (!f.proto) begin
                        f.proto = 1'b1;
                        first   = 1'b1;
                    end
                    cls = CL_PROTO;
                end
            end
            PH_REQ_END, PH_HDR_END: begin
                if (c == CH_LF) begin
                    phase    = PH_HEADER;
                    line_gap = 2'd1;
                end else begin
                    phase = PH_BAD_LINE;
                end
            end
            PH_HEADER: begin
                if (line_gap == 2'd1 && c == CH_CR) begin
                    line_gap = 2'd2;
                end else if (line_gap == 2'd2 && c == CH_LF) begin
                    line_gap = 2'd0;
                    if (len_seen != '0) begin
                        body_left = len_seen;
                        phase     = PH_BODY;
                    end else begin
                        phase = PH_DONE;
                    end
                end else begin
                    line_gap = 2'd0;
                    if (skip && !f.hkey) begin
                    end else if (c == CH_COLON) begin
                        if (f.hkey && !f.colon) begin
                            f.hkdone = 1'b1;
                            f.colon  = 1'b1;
                            closed   = 1'b1;
                            if (kpos == KPOS_FULL) len_seen = '0;
                            else kpos = KPOS_MISS;
                        end else if (f.hval) begin
                            cls = CL_HVAL;
                            take_value(c);
                        end
                    end else if (c == CH_CR) begin
                        if (f.hval || !f.colon) closed = 1'b1;
                        f.hkey   = 1'b0;
                        f.hval   = 1'b0;
                        f.hkdone = 1'b0;
                        f.colon  = 1'b0;
                        phase    = PH_HDR_END;
                    end else begin
                        if (!f.hkey) begin
                            f.hkey = 1'b1;
                            kpos   = '0;
                            first  = 1'b1;
                        end
                        if (f.hkdone && !f.hval) begin
                            f.hval   = 1'b1;
                            f.hkdone = 1'b0;
                            first    = 1'b1;
                        end
                        if (f.hval) begin
                            cls = CL_HVAL;
                            take_value(c);
                        end else begin
                            cls = CL_HKEY;
                            if (!f.colon && c != CH_SP) begin
                                if (kpos < KPOS_FULL && c == LEN_KEY[kpos]) kpos = kpos + 4'd1;
                                else kpos = KPOS_MISS;
                            end
                        end
                    end
                end
            end
            PH_BODY: begin
                cls = CL_BODY;
                if (body_left == len_seen) first = 1'b1;
                if (body_left != '0) body_left = body_left - 1'b1;
                if (body_left == '0) phase = PH_DONE;
            end
            default: begin
            end
        endcase
        flags = f;
        case (phase)
            PH_DONE:     st = ST_DONE;
            PH_BAD_METH: st = ST_BAD_METHOD;
            PH_BAD_URI:  st = ST_BAD_URI;
            PH_BAD_VER:  st = ST_BAD_VERSION;
            PH_BAD_LINE: st = ST_BAD_LINE;
            default:     st = ST_BUSY;
        endcase
        rec.cls    = cls;
        rec.first  = first;
        rec.closed = closed;
        rec.status = st;
        rec.len    = len_seen;
    endtask

    task automatic check_field(input string what, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0d, got %0d", $time, what, want, got);
            mismatch_count = mismatch_count + 1;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            parser_clear();
            expected_tags.delete();
        end else begin
            if (i_res_valid === 1'b1 && i_res_stall === 1'b0) begin
                if (expected_tags.size() == 0) begin
                    $display("%0t: tag expected none, got class %0d status %0d",
                             $time, i_res_class, i_res_status);
                    mismatch_count = mismatch_count + 1;
                end else begin
                    head = expected_tags.pop_front();
                    check_field("byte class", 32'(head.cls), 32'(i_res_class));
                    check_field("token first", 32'(head.first), 32'(i_res_first));
                    check_field("token closed", 32'(head.closed), 32'(i_res_closed));
                    check_field("status", 32'(head.status), 32'(i_res_status));
                    check_field("body length", 32'(head.len), 32'(i_res_length));
                end
            end
            if (i_req_valid === 1'b1 && i_req_stall === 1'b0) begin
                tag_byte(i_req_byte, i_req_new, next_tag);
                expected_tags.push_back(next_tag);
            end
        end
        o_pending <= expected_tags.size();
    end

endmodule

`default_nettype wire

// ----- tb/http_request_byte_tagger_tb.sv -----
// http_request_byte_tagger_tb: drives request bytes into the tagger, mostly well-formed
// requests with random content plus corrupted ones and noise, stalls the result side
// at random and gives the verdict. Depends on hrbt_pkg, hrbt_tag_checker and the block.
`default_nettype none

module http_request_byte_tagger_tb;
    import hrbt_pkg::*;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    logic [7:0]            in_byte;
    logic                  in_new;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [CLASS_W-1:0]    out_class;
    logic                  out_first;
    logic                  out_closed;
    logic [STATUS_W-1:0]   out_status;
    logic [BODY_LEN_W-1:0] out_length;

    int    fail_count;
    int    pending;
    int    sent_count;
    int    stall_run = 0;
    int    stall_pick;
    logic  gapless;
    logic  text_fresh;
    t_byte text[$];

    http_request_byte_tagger i_dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_valid        (in_valid),
        .o_stall        (in_stall),
        .i_data_byte    (in_byte),
        .i_new_request  (in_new),
        .o_valid        (out_valid),
        .i_stall        (out_stall),
        .o_byte_class   (out_class),
        .o_token_first  (out_first),
        .o_token_closed (out_closed),
        .o_status       (out_status),
        .o_body_length  (out_length)
    );

    hrbt_tag_checker i_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_req_valid  (in_valid),
        .i_req_stall  (in_stall),
        .i_req_byte   (in_byte),
        .i_req_new    (in_new),
        .i_res_valid  (out_valid),
        .i_res_stall  (out_stall),
        .i_res_class  (out_class),
        .i_res_first  (out_first),
        .i_res_closed (out_closed),
        .i_res_status (out_status),
        .i_res_length (out_length),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial clk = 1'b0;
    always #4 clk = ~clk;

    initial begin
        #6_000_000;
        $display("http_request_byte_tagger_tb NOT OK");
        $finish;
    end

    // result side back-pressure: short stalls, a few long ones, long free stretches
    always @(posedge clk) begin
        if (stall_run > 0) begin
            stall_run <= stall_run - 1;
        end else begin
            stall_pick = $urandom_range(0, 99);
            if (stall_pick < 30) begin
                out_stall <= 1'b1;
                stall_run <= ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40)
                                                          : $urandom_range(0, 2);
            end else begin
                out_stall <= 1'b0;
                stall_run <= ($urandom_range(0, 7) == 0) ? $urandom_range(40, 200)
                                                          : $urandom_range(0, 12);
            end
        end
    end

    task automatic send_byte(input t_byte b, input logic fresh);
        int gap;
        int r;
        r = $urandom_range(0, 99);
        if (gapless || r < 65) gap = 0;
        else if (r < 90) gap = $urandom_range(1, 3);
        else if (r < 98) gap = $urandom_range(4, 12);
        else gap = $urandom_range(20, 60);
        if (gap > 0) begin
            if (in_valid) in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_byte  <= b;
        in_new   <= fresh;
        @(posedge clk);
        while (in_stall !== 1'b0) @(posedge clk);
    endtask

    task automatic run_text();
        int i;
        for (i = 0; i < text.size(); i++) begin
            send_byte(text[i], (i == 0) ? text_fresh : ($urandom_range(0, 299) == 0));
            sent_count = sent_count + 1;
        end
    endtask

    task automatic drain();
        if (in_valid) in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    task automatic push_str(input string s);
        int i;
        for (i = 0; i < s.len(); i++) text.push_back(s[i]);
    endtask

    task automatic push_word(input int lo, input int hi);
        int k;
        repeat ($urandom_range(lo, hi)) begin
            k = $urandom_range(0, 61);
            if (k < 26) text.push_back(t_byte'(8'h61 + k));
            else if (k < 52) text.push_back(t_byte'(8'h41 + k - 26));
            else text.push_back(t_byte'(8'h30 + k - 52));
        end
    endtask

    task automatic build_request();
        int    r;
        int    i;
        int    n;
        int    val;
        int    body;
        string key;
        text.delete();
        body = 0;
        if ($urandom_range(0, 4) == 0) begin
            repeat ($urandom_range(1, 3)) begin
                r = $urandom_range(0, 2);
                text.push_back(r == 0 ? CH_CR : (r == 1 ? CH_LF : CH_SP));
            end
        end
        repeat ($urandom_range(1, 7)) text.push_back(t_byte'(8'h41 + $urandom_range(0, 25)));
        if ($urandom_range(0, 9) == 0) text.push_back(t_byte'(8'h30 + $urandom_range(0, 9)));
        text.push_back(($urandom_range(0, 3) == 0) ? CH_TAB : CH_SP);
        if ($urandom_range(0, 7) == 0) push_str("http:");
        text.push_back(CH_SLASH);
        repeat ($urandom_range(0, 3)) begin
            push_word(0, 5);
            if ($urandom_range(0, 1) == 0) text.push_back(CH_SLASH);
        end
        // query string
        if ($urandom_range(0, 2) == 0) begin
            text.push_back(CH_QUEST);
            n = ($urandom_range(0, 11) == 0) ? 0 : $urandom_range(1, 3);
            for (i = 0; i < n; i++) begin
                if (i > 0) text.push_back(CH_AMP);
                push_word(($urandom_range(0, 7) == 0) ? 0 : 1, 4);
                if ($urandom_range(0, 2) != 0) begin
                    text.push_back(CH_EQ);
                    if ($urandom_range(0, 9) == 0) text.push_back(CH_EQ);
                    push_word(0, 4);
                end
            end
        end
        text.push_back(CH_SP);
        if ($urandom_range(0, 3) != 0) push_str("HTTP");
        else repeat ($urandom_range(1, 5)) text.push_back(t_byte'(8'h41 + $urandom_range(0, 25)));
        text.push_back(CH_SLASH);
        r = $urandom_range(0, 11);
        if (r != 0) begin
            if (r == 2) text.push_back(CH_SP);
            text.push_back(t_byte'(8'h30 + $urandom_range(0, 9)));
            text.push_back(CH_DOT);
            text.push_back(t_byte'(8'h30 + $urandom_range(0, 9)));
            if (r == 1) push_str("x");
        end
        text.push_back(CH_CR);
        text.push_back(CH_LF);
        // header lines
        repeat ($urandom_range(0, 4)) begin
            if ($urandom_range(0, 9) == 0) text.push_back(CH_SP);
            if ($urandom_range(0, 2) == 0) begin
                r = $urandom_range(0, 7);
                if (r == 0) key = "content-length";
                else if (r == 1) key = "Content-Lengths";
                else key = "Content-Length";
                for (i = 0; i < key.len(); i++) begin
                    text.push_back(key[i]);
                    if ($urandom_range(0, 11) == 0) text.push_back(CH_SP);
                end
                text.push_back(CH_COLON);
                if ($urandom_range(0, 1) == 0) text.push_back(CH_SP);
                n = $urandom_range(0, 11);
                if (n == 0) begin
                    push_str("99999999999");
                    val = 0;
                end else begin
                    val = (n < 4) ? 0 : $urandom_range(1, 16);
                    push_str($sformatf("%0d", val));
                end
                if ($urandom_range(0, 5) == 0) push_str(" ;q");
                if (r > 1) body = val;
            end else begin
                push_word(1, 8);
                if ($urandom_range(0, 19) != 0) begin
                    text.push_back(CH_COLON);
                    if ($urandom_range(0, 1) == 0) text.push_back(CH_SP);
                    push_word(0, 10);
                    if ($urandom_range(0, 4) == 0) begin
                        text.push_back(CH_COLON);
                        push_word(0, 3);
                    end
                end
            end
            text.push_back(CH_CR);
            text.push_back(CH_LF);
        end
        text.push_back(CH_CR);
        text.push_back(CH_LF);
        repeat (body) text.push_back(t_byte'($urandom_range(0, 255)));
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 3)) text.push_back(t_byte'($urandom_range(0, 255)));
        // broken requests
        if ($urandom_range(0, 5) == 0)
            text[$urandom_range(0, text.size() - 1)] = t_byte'($urandom_range(0, 255));
        if ($urandom_range(0, 9) == 0) begin
            n = $urandom_range(1, text.size());
            while (text.size() > n) void'(text.pop_back());
        end
    endtask

    initial begin
        int guard;
        in_valid   <= 1'b0;
        in_byte    <= '0;
        in_new     <= 1'b0;
        rst_n      <= 1'b0;
        gapless    = 1'b0;
        sent_count = 0;
        text_fresh = 1'b1;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // leading blanks, extreme bytes, bad method, ignored after failure
        text.delete();
        text.push_back(CH_CR);
        text.push_back(CH_SP);
        text.push_back(8'hFF);
        text.push_back(8'h00);
        run_text();
        // odd byte in method, junk before path, empty query
        text.delete();
        push_str("G1 x/? ");
        run_text();
        // bad version after a digit
        text.delete();
        push_str("P /");
        text.push_back(CH_TAB);
        push_str("H/1x");
        run_text();
        // no version, headers end right after request line
        text.delete();
        push_str("A /\t/");
        text.push_back(CH_CR);
        text.push_back(CH_LF);
        text.push_back(CH_CR);
        text.push_back(CH_LF);
        run_text();
        // bad line end
        text.delete();
        push_str("Q /\t/");
        text.push_back(CH_CR);
        push_str("x");
        run_text();
        drain();

        while (sent_count < 1300) begin
            if ($urandom_range(0, 9) == 0) begin
                text.delete();
                repeat ($urandom_range(1, 12)) text.push_back(t_byte'($urandom_range(0, 255)));
                text_fresh = $urandom_range(0, 1);
            end else begin
                build_request();
                text_fresh = 1'b1;
            end
            gapless = ($urandom_range(0, 3) == 0);
            run_text();
            if ($urandom_range(0, 7) == 0) drain();
        end

        if (in_valid) in_valid <= 1'b0;
        guard = 0;
        while (pending != 0 && guard < 20000) begin
            @(posedge clk);
            guard = guard + 1;
        end
        repeat (10) @(posedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("http_request_byte_tagger_tb OK");
        end else begin
            $display("http_request_byte_tagger_tb NOT OK");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ----- http_request_byte_tagger.f -----
sv/hrbt_pkg.sv
sv/hrbt_step.sv
sv/http_request_byte_tagger.sv
tb/hrbt_tag_checker.sv
tb/http_request_byte_tagger_tb.sv
